### hw/rtl/ect_pkg.sv
// Shared types and constants of the ear clipping triangulator.
package ect_pkg;

    localparam int unsigned IDX_W   = 16;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned DIFF_W  = 17;
    localparam int unsigned DOT_W   = 35;
    localparam int unsigned WIDE_W  = 72;
    localparam int unsigned CORNER_W = IDX_W + 3 * COORD_W;
    localparam int unsigned TRI_W   = 3 * IDX_W;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        ST_TRI   = 2'd0,
        ST_DEGEN = 2'd1,
        ST_FEW   = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    // Multiplier operand selects.
    typedef enum logic [3:0] {
        MS_E0X, MS_E0Y, MS_E0Z,
        MS_E1X, MS_E1Y, MS_E1Z,
        MS_E2X, MS_E2Y, MS_E2Z,
        MS_D00, MS_D01, MS_D02, MS_D11, MS_D12
    } t_msel;

    typedef enum logic [1:0] {AO_NOP, AO_LOAD, AO_ADD, AO_SUB} t_aop;

    typedef enum logic [3:0] {
        DS_NONE, DS_D00, DS_D01, DS_D02, DS_D11, DS_D12,
        DS_DD, DS_UU, DS_VV, DS_CROSS
    } t_dst;

    typedef enum logic [2:0] {SL_NONE, SL_A, SL_B, SL_C, SL_P} t_slot;

    typedef enum logic [1:0] {DF_NONE, DF_CROSS, DF_IN} t_diff;

    typedef struct packed {
        t_msel ma;
        t_msel mb;
        t_aop  aop;
        t_dst  dst;
    } t_mop;

    localparam t_mop MOP_NOP = '{ma: MS_E0X, mb: MS_E0X, aop: AO_NOP, dst: DS_NONE};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cwr;
        t_slot   crd;
        logic    ord_rd;
        t_slot   ord_dst;
        logic    ord_wr;
        logic    ord_wsrc;
        t_diff   diff;
        t_mop    mop;
        logic    out_ld;
        t_status out_st;
        logic    out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cross_pos;
        logic pt_in;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/ear_clipping_triangulator.sv
// Top level of the ear clipping triangulator: controller, datapath and port wiring.
//
// The input stream carries the corners of one polygon face, one beat per corner.
// A corner is taken whenever s_axis_tready is high and stored in a small corner memory; the beat
// with tlast set ends the face and starts triangulation. While triangulating,
// s_axis_tready stays low. Each ear found leaves as one output beat with the
// three mesh indices and tuser 0; the final triangle carries tlast. A face of
// fewer than three corners, a face that overflowed MAX_VERTS, or a face with
// no ear gives one beat with tuser 2, 3 or 1, zero indices and tlast set.
// Every candidate corner goes through order and corner fetch and the cross product,
// and every corner tested against an ear through the dot products and barycentric
// terms, which the single shared 35x35 multiplier computes in sequence.
// When the output is stalled, the controller holds until the output register
// frees; after the last beat of a face is loaded, new corners are accepted
// even while that beat waits. Reset returns to the idle state with no corners
// stored; memory contents are left as they are and are rewritten per face.
module ear_clipping_triangulator import ect_pkg::*; #(
    parameter int unsigned MAX_VERTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // vertex_index[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48]
    input  logic [CORNER_W-1:0] s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tri_a[15:0], tri_b[31:16], tri_c[47:32]
    output logic [TRI_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [1:0]          m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int unsigned AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int unsigned CW = $clog2(MAX_VERTS + 1);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_cwr_addr, w_ord_addr, w_ord_wdata;

    ect_ctrl #(
        .MAX_VERTS (MAX_VERTS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_cwr_addr  (w_cwr_addr),
        .o_ord_addr  (w_ord_addr),
        .o_ord_wdata (w_ord_wdata)
    );

    ect_dp #(
        .MAX_VERTS (MAX_VERTS),
        .AW        (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cwr_addr   (w_cwr_addr),
        .i_ord_addr   (w_ord_addr),
        .i_ord_wdata  (w_ord_wdata),
        .i_in_data    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

`ifndef SYNTH
    // Every non-triangle result closes its face.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_TRI) |-> m_axis_tlast)
        else $error("status beat without tlast");

    // Non-triangle results carry zero indices.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_TRI) |-> (m_axis_tdata == '0))
        else $error("status beat with nonzero indices");

    // A face end always stops input intake for at least the next cycle.
    a_face_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after face end");
`endif

endmodule

### hw/rtl/ect_dp.sv
// Datapath: corner and order memories, difference unit, shared multiplier and output register.
module ect_dp import ect_pkg::*; #(
    parameter int unsigned MAX_VERTS = 16,
    parameter int unsigned AW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [AW-1:0]       i_cwr_addr,
    input  logic [AW-1:0]       i_ord_addr,
    input  logic [AW-1:0]       i_ord_wdata,
    input  logic [CORNER_W-1:0] i_in_data,
    input  logic                i_out_ready,
    output t_sts                o_sts,
    output logic                o_out_valid,
    output logic [TRI_W-1:0]    o_out_data,
    output logic [1:0]          o_out_status,
    output logic                o_out_last
);

    logic [CORNER_W-1:0] r_cmem [MAX_VERTS];
    logic [AW-1:0]       r_omem [MAX_VERTS];
    logic [CORNER_W-1:0] r_crd;
    t_slot               r_crd_dst;
    logic [AW-1:0]       r_ord;
    t_slot               r_ord_dst;
    logic [AW-1:0]       r_sa, r_sb, r_sc, r_sp;
    logic [CORNER_W-1:0] r_ca, r_cb, r_cc, r_cp;
    logic signed [DIFF_W-1:0] r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z;
    logic signed [DIFF_W-1:0] r_e2x, r_e2y, r_e2z;
    logic signed [WIDE_W-1:0] r_prod, r_acc, r_dd, r_uu, r_vv;
    t_aop                r_pop;
    t_dst                r_pdst;
    logic signed [DOT_W-1:0] r_d00, r_d01, r_d02, r_d11, r_d12, r_cross;
    logic                r_ov;
    logic [TRI_W-1:0]    r_odata;
    logic [1:0]          r_ost;
    logic                r_olast;

    logic [AW-1:0]       w_craddr;
    logic signed [DOT_W-1:0] w_ma, w_mb;
    logic signed [2*DOT_W-1:0] w_prod;
    logic signed [WIDE_W-1:0] n_acc, w_sum;

    function automatic logic signed [DIFF_W-1:0] f_sub(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        f_sub = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic logic [COORD_W-1:0] f_x(input logic [CORNER_W-1:0] c);
        f_x = c[IDX_W +: COORD_W];
    endfunction
    function automatic logic [COORD_W-1:0] f_y(input logic [CORNER_W-1:0] c);
        f_y = c[IDX_W+COORD_W +: COORD_W];
    endfunction
    function automatic logic [COORD_W-1:0] f_z(input logic [CORNER_W-1:0] c);
        f_z = c[IDX_W+2*COORD_W +: COORD_W];
    endfunction

    function automatic logic signed [DOT_W-1:0] f_ext(input logic signed [DIFF_W-1:0] v);
        f_ext = DOT_W'(v);
    endfunction

    function automatic logic signed [DOT_W-1:0] f_opnd(
        input t_msel s,
        input logic signed [DIFF_W-1:0] e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z,
        input logic signed [DOT_W-1:0] d00, d01, d02, d11, d12
    );
        unique case (s)
            MS_E0X:  f_opnd = f_ext(e0x);
            MS_E0Y:  f_opnd = f_ext(e0y);
            MS_E0Z:  f_opnd = f_ext(e0z);
            MS_E1X:  f_opnd = f_ext(e1x);
            MS_E1Y:  f_opnd = f_ext(e1y);
            MS_E1Z:  f_opnd = f_ext(e1z);
            MS_E2X:  f_opnd = f_ext(e2x);
            MS_E2Y:  f_opnd = f_ext(e2y);
            MS_E2Z:  f_opnd = f_ext(e2z);
            MS_D00:  f_opnd = d00;
            MS_D01:  f_opnd = d01;
            MS_D02:  f_opnd = d02;
            MS_D11:  f_opnd = d11;
            MS_D12:  f_opnd = d12;
            default: f_opnd = '0;
        endcase
    endfunction

    always_comb begin
        unique case (i_cmd.crd)
            SL_A:    w_craddr = r_sa;
            SL_B:    w_craddr = r_sb;
            SL_C:    w_craddr = r_sc;
            SL_P:    w_craddr = r_sp;
            default: w_craddr = r_sa;
        endcase
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cwr) begin
            r_cmem[i_cwr_addr] <= i_in_data;
        end
        r_crd <= r_cmem[w_craddr];
        if (i_cmd.ord_wr) begin
            r_omem[i_ord_addr] <= i_cmd.ord_wsrc ? r_ord : i_ord_wdata;
        end
        r_ord <= r_omem[i_ord_addr];
    end

    assign w_ma   = f_opnd(i_cmd.mop.ma, r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z,
                           r_e2x, r_e2y, r_e2z, r_d00, r_d01, r_d02, r_d11, r_d12);
    assign w_mb   = f_opnd(i_cmd.mop.mb, r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z,
                           r_e2x, r_e2y, r_e2z, r_d00, r_d01, r_d02, r_d11, r_d12);
    assign w_prod = w_ma * w_mb;

    always_comb begin
        unique case (r_pop)
            AO_LOAD: n_acc = r_prod;
            AO_ADD:  n_acc = r_acc + r_prod;
            AO_SUB:  n_acc = r_acc - r_prod;
            default: n_acc = r_acc;
        endcase
    end

    // The three wide terms stay well inside the accumulator width.
    assign w_sum = r_uu + r_vv - r_dd;

    assign o_sts.cross_pos = (r_cross > 0);
    assign o_sts.pt_in     = (r_dd != '0) && (r_uu > 0) && (r_vv > 0) && (w_sum < 0);
    assign o_sts.out_free  = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crd_dst <= SL_NONE;
            r_ord_dst <= SL_NONE;
            r_pop     <= AO_NOP;
            r_pdst    <= DS_NONE;
            r_ov      <= 1'b0;
        end else begin
            r_crd_dst <= i_cmd.crd;
            r_ord_dst <= i_cmd.ord_rd ? i_cmd.ord_dst : SL_NONE;
            r_pop     <= i_cmd.mop.aop;
            r_pdst    <= i_cmd.mop.dst;
            if (i_cmd.out_ld) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_ord_dst)
            SL_A:    r_sa <= r_ord;
            SL_B:    r_sb <= r_ord;
            SL_C:    r_sc <= r_ord;
            SL_P:    r_sp <= r_ord;
            default: ;
        endcase
        unique case (r_crd_dst)
            SL_A:    r_ca <= r_crd;
            SL_B:    r_cb <= r_crd;
            SL_C:    r_cc <= r_crd;
            SL_P:    r_cp <= r_crd;
            default: ;
        endcase
        unique case (i_cmd.diff)
            DF_CROSS: begin
                r_e1x <= f_sub(f_x(r_cb), f_x(r_ca));
                r_e1y <= f_sub(f_y(r_cb), f_y(r_ca));
                r_e2x <= f_sub(f_x(r_cc), f_x(r_cb));
                r_e2y <= f_sub(f_y(r_cc), f_y(r_cb));
            end
            DF_IN: begin
                r_e0x <= f_sub(f_x(r_cc), f_x(r_ca));
                r_e0y <= f_sub(f_y(r_cc), f_y(r_ca));
                r_e0z <= f_sub(f_z(r_cc), f_z(r_ca));
                r_e1x <= f_sub(f_x(r_cb), f_x(r_ca));
                r_e1y <= f_sub(f_y(r_cb), f_y(r_ca));
                r_e1z <= f_sub(f_z(r_cb), f_z(r_ca));
                r_e2x <= f_sub(f_x(r_cp), f_x(r_ca));
                r_e2y <= f_sub(f_y(r_cp), f_y(r_ca));
                r_e2z <= f_sub(f_z(r_cp), f_z(r_ca));
            end
            default: ;
        endcase
        r_prod <= {{(WIDE_W-2*DOT_W){w_prod[2*DOT_W-1]}}, w_prod};
        r_acc  <= n_acc;
        unique case (r_pdst)
            DS_D00:   r_d00   <= n_acc[DOT_W-1:0];
            DS_D01:   r_d01   <= n_acc[DOT_W-1:0];
            DS_D02:   r_d02   <= n_acc[DOT_W-1:0];
            DS_D11:   r_d11   <= n_acc[DOT_W-1:0];
            DS_D12:   r_d12   <= n_acc[DOT_W-1:0];
            DS_DD:    r_dd    <= n_acc;
            DS_UU:    r_uu    <= n_acc;
            DS_VV:    r_vv    <= n_acc;
            DS_CROSS: r_cross <= n_acc[DOT_W-1:0];
            default:  ;
        endcase
        if (i_cmd.out_ld) begin
            r_ost   <= i_cmd.out_st;
            r_olast <= i_cmd.out_last;
            if (i_cmd.out_st == ST_TRI) begin
                r_odata <= {r_cc[IDX_W-1:0], r_cb[IDX_W-1:0], r_ca[IDX_W-1:0]};
            end else begin
                r_odata <= '0;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_data   = r_odata;
    assign o_out_status = r_ost;
    assign o_out_last   = r_olast;

endmodule

### hw/rtl/ect_ctrl.sv
// Controller: loads corners and sequences the ear search over the datapath.
module ect_ctrl import ect_pkg::*; #(
    parameter int unsigned MAX_VERTS = 16,
    parameter int unsigned AW = 4,
    parameter int unsigned CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  t_sts          i_sts,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_cwr_addr,
    output logic [AW-1:0] o_ord_addr,
    output logic [AW-1:0] o_ord_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_INIT, S_OUTER, S_FETCH, S_DCROSS, S_CROSS, S_CHKX,
        S_JLOOP, S_PFETCH, S_DIN, S_MICRO, S_EVAL, S_EMIT, S_SHIFT, S_AFTER, S_EMITF
    } t_state;

    localparam logic [CW-1:0] MAXC  = CW'(MAX_VERTS);
    localparam logic [CW-1:0] THREE = CW'(3);
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [4:0] UC_IN_LAST = 5'd21;
    localparam logic [4:0] UC_CR_FIRST = 5'd22;
    localparam logic [4:0] UC_CR_LAST = 5'd24;
    localparam logic [2:0] FETCH_LAST = 3'd6;
    localparam logic [2:0] PFETCH_LAST = 3'd3;

    t_state        r_state;
    logic [CW-1:0] r_cnt, r_m, r_i, r_j;
    logic          r_ovf, r_final, r_ph;
    logic [2:0]    r_sub;
    logic [4:0]    r_uc;
    t_status       r_kind;

    logic [CW-1:0] w_ip, w_in2, w_j1;
    logic          w_take;

    // Micro-program of the shared multiplier: dot products and the wide
    // barycentric terms first, then the corner cross product.
    function automatic t_mop f_rom(input logic [4:0] a);
        unique case (a)
            5'd0:  f_rom = '{MS_E0X, MS_E0X, AO_LOAD, DS_NONE};
            5'd1:  f_rom = '{MS_E0Y, MS_E0Y, AO_ADD,  DS_NONE};
            5'd2:  f_rom = '{MS_E0Z, MS_E0Z, AO_ADD,  DS_D00};
            5'd3:  f_rom = '{MS_E0X, MS_E1X, AO_LOAD, DS_NONE};
            5'd4:  f_rom = '{MS_E0Y, MS_E1Y, AO_ADD,  DS_NONE};
            5'd5:  f_rom = '{MS_E0Z, MS_E1Z, AO_ADD,  DS_D01};
            5'd6:  f_rom = '{MS_E0X, MS_E2X, AO_LOAD, DS_NONE};
            5'd7:  f_rom = '{MS_E0Y, MS_E2Y, AO_ADD,  DS_NONE};
            5'd8:  f_rom = '{MS_E0Z, MS_E2Z, AO_ADD,  DS_D02};
            5'd9:  f_rom = '{MS_E1X, MS_E1X, AO_LOAD, DS_NONE};
            5'd10: f_rom = '{MS_E1Y, MS_E1Y, AO_ADD,  DS_NONE};
            5'd11: f_rom = '{MS_E1Z, MS_E1Z, AO_ADD,  DS_D11};
            5'd12: f_rom = '{MS_E1X, MS_E2X, AO_LOAD, DS_NONE};
            5'd13: f_rom = '{MS_E1Y, MS_E2Y, AO_ADD,  DS_NONE};
            5'd14: f_rom = '{MS_E1Z, MS_E2Z, AO_ADD,  DS_D12};
            5'd15: f_rom = '{MS_D00, MS_D11, AO_LOAD, DS_NONE};
            5'd16: f_rom = '{MS_D01, MS_D01, AO_SUB,  DS_DD};
            5'd17: f_rom = '{MS_D11, MS_D02, AO_LOAD, DS_NONE};
            5'd18: f_rom = '{MS_D01, MS_D12, AO_SUB,  DS_UU};
            5'd19: f_rom = '{MS_D00, MS_D12, AO_LOAD, DS_NONE};
            5'd20: f_rom = '{MS_D01, MS_D02, AO_SUB,  DS_VV};
            5'd22: f_rom = '{MS_E1X, MS_E2Y, AO_LOAD, DS_NONE};
            5'd23: f_rom = '{MS_E1Y, MS_E2X, AO_SUB,  DS_CROSS};
            default: f_rom = MOP_NOP;
        endcase
    endfunction

    assign w_ip   = (r_i == '0) ? r_m - ONE : r_i - ONE;
    assign w_in2  = (r_i == r_m - ONE) ? '0 : r_i + ONE;
    assign w_j1   = r_j + ONE;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_take = o_in_ready && i_in_valid;
    assign o_cwr_addr = r_cnt[AW-1:0];
    assign o_ord_wdata = r_i[AW-1:0];

    always_comb begin
        o_cmd          = '0;
        o_cmd.crd      = SL_NONE;
        o_cmd.ord_dst  = SL_NONE;
        o_cmd.diff     = DF_NONE;
        o_cmd.mop      = MOP_NOP;
        o_cmd.out_st   = ST_TRI;
        o_ord_addr     = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: o_cmd.cwr = w_take && (r_cnt < MAXC);
            S_INIT: o_cmd.ord_wr = 1'b1;
            S_FETCH: begin
                unique case (r_sub)
                    3'd0: begin
                        o_cmd.ord_rd = 1'b1;
                        o_cmd.ord_dst = SL_A;
                        o_ord_addr = w_ip[AW-1:0];
                    end
                    3'd1: begin
                        o_cmd.ord_rd = 1'b1;
                        o_cmd.ord_dst = SL_B;
                    end
                    3'd2: begin
                        o_cmd.ord_rd = 1'b1;
                        o_cmd.ord_dst = SL_C;
                        o_ord_addr = w_in2[AW-1:0];
                    end
                    3'd3: o_cmd.crd = SL_A;
                    3'd4: o_cmd.crd = SL_B;
                    3'd5: o_cmd.crd = SL_C;
                    default: ;
                endcase
            end
            S_PFETCH: begin
                o_ord_addr = r_j[AW-1:0];
                if (r_sub == 3'd0) begin
                    o_cmd.ord_rd = 1'b1;
                    o_cmd.ord_dst = SL_P;
                end
                if (r_sub == 3'd2) begin
                    o_cmd.crd = SL_P;
                end
            end
            S_DCROSS: o_cmd.diff = DF_CROSS;
            S_DIN:    o_cmd.diff = DF_IN;
            S_CROSS, S_MICRO: o_cmd.mop = f_rom(r_uc);
            S_EMIT: o_cmd.out_ld = i_sts.out_free;
            S_SHIFT: begin
                if (!r_ph) begin
                    o_ord_addr = w_j1[AW-1:0];
                end else begin
                    o_ord_addr = r_j[AW-1:0];
                    o_cmd.ord_wr = (w_j1 < r_m);
                    o_cmd.ord_wsrc = 1'b1;
                end
            end
            S_EMITF: begin
                o_cmd.out_ld = i_sts.out_free;
                o_cmd.out_st = r_kind;
                o_cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_final <= 1'b0;
            r_ph    <= 1'b0;
            r_m     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_sub   <= '0;
            r_uc    <= '0;
            r_kind  <= ST_TRI;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (r_cnt < MAXC) begin
                            r_cnt <= r_cnt + ONE;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_last) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_m <= r_cnt;
                    r_i <= '0;
                    priority if (r_ovf) begin
                        r_kind  <= ST_OVF;
                        r_state <= S_EMITF;
                    end else if (r_cnt < THREE) begin
                        r_kind  <= ST_FEW;
                        r_state <= S_EMITF;
                    end else begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    if (r_i == r_m - ONE) begin
                        r_sub <= '0;
                        if (r_m == THREE) begin
                            r_i     <= ONE;
                            r_final <= 1'b1;
                            r_state <= S_FETCH;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_OUTER;
                        end
                    end else begin
                        r_i <= r_i + ONE;
                    end
                end
                S_OUTER: begin
                    r_sub <= '0;
                    if (r_i == r_m) begin
                        r_kind  <= ST_DEGEN;
                        r_state <= S_EMITF;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_sub <= r_sub + 3'd1;
                    if (r_sub == FETCH_LAST) begin
                        if (r_final) begin
                            r_kind  <= ST_TRI;
                            r_state <= S_EMITF;
                        end else begin
                            r_state <= S_DCROSS;
                        end
                    end
                end
                S_DCROSS: begin
                    r_uc    <= UC_CR_FIRST;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_uc <= r_uc + 5'd1;
                    if (r_uc == UC_CR_LAST) begin
                        r_state <= S_CHKX;
                    end
                end
                S_CHKX: begin
                    if (i_sts.cross_pos) begin
                        r_j     <= '0;
                        r_state <= S_JLOOP;
                    end else begin
                        r_i     <= r_i + ONE;
                        r_state <= S_OUTER;
                    end
                end
                S_JLOOP: begin
                    r_sub <= '0;
                    priority if (r_j == r_m) begin
                        r_state <= S_EMIT;
                    end else if (r_j == w_ip || r_j == r_i || r_j == w_in2) begin
                        r_j <= w_j1;
                    end else begin
                        r_state <= S_PFETCH;
                    end
                end
                S_PFETCH: begin
                    r_sub <= r_sub + 3'd1;
                    if (r_sub == PFETCH_LAST) begin
                        r_state <= S_DIN;
                    end
                end
                S_DIN: begin
                    r_uc    <= '0;
                    r_state <= S_MICRO;
                end
                S_MICRO: begin
                    r_uc <= r_uc + 5'd1;
                    if (r_uc == UC_IN_LAST) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (i_sts.pt_in) begin
                        r_i     <= r_i + ONE;
                        r_state <= S_OUTER;
                    end else begin
                        r_j     <= w_j1;
                        r_state <= S_JLOOP;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_j     <= r_i;
                        r_ph    <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (w_j1 < r_m) begin
                        r_ph <= !r_ph;
                        if (r_ph) begin
                            r_j <= w_j1;
                        end
                    end else begin
                        r_m     <= r_m - ONE;
                        r_state <= S_AFTER;
                    end
                end
                S_AFTER: begin
                    r_sub <= '0;
                    if (r_m == THREE) begin
                        r_i     <= ONE;
                        r_final <= 1'b1;
                        r_state <= S_FETCH;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_OUTER;
                    end
                end
                S_EMITF: begin
                    if (i_sts.out_free) begin
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_final <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/sv/ear_clipping_triangulator_tb.sv
// Self-checking testbench for the ear clipping triangulator stream block.
`timescale 1ns / 1ps

module ear_clipping_triangulator_tb import ect_pkg::*; ();

    localparam int unsigned MAX_VERTS = 16;
    localparam longint RUN_LIMIT = 3000000;

    typedef struct {
        logic [15:0]        idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } corner_t;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        t_status     st;
        logic        last;
    } tri_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // vertex_index[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48]
    logic [CORNER_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tri_a[15:0], tri_b[31:16], tri_c[47:32]
    logic [TRI_W-1:0]    m_axis_tdata;
    // status[1:0]
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    corner_t corner_queue[$];
    tri_t    expected_tris[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      steady_in = 0;
    bit      steady_out = 0;
    int      in_gap = 0;
    int      out_stall = 0;

    // Predictor copy of the face being loaded.
    logic [15:0] face_idx[MAX_VERTS];
    longint      face_x[MAX_VERTS];
    longint      face_y[MAX_VERTS];
    longint      face_z[MAX_VERTS];
    int          face_count = 0;
    bit          face_overflow = 0;

    int dir_x[16] = '{1000, 924, 707, 383, 0, -383, -707, -924,
                      -1000, -924, -707, -383, 0, 383, 707, 924};
    int dir_y[16] = '{0, 383, 707, 924, 1000, 924, 707, 383,
                      0, -383, -707, -924, -1000, -924, -707, -383};

    ear_clipping_triangulator #(.MAX_VERTS(MAX_VERTS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic void add_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                    t_status st, logic last);
        tri_t t;
        t.a = a; t.b = b; t.c = c; t.st = st; t.last = last;
        expected_tris.insert(expected_tris.size(), t);
    endfunction

    // Strict point-in-triangle test with exact wide arithmetic.
    function automatic bit strictly_inside(int p, int a, int b, int c);
        longint e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [127:0] d00, d01, d02, d11, d12, den, u, v;
        e0x = face_x[c] - face_x[a]; e0y = face_y[c] - face_y[a];
        e0z = face_z[c] - face_z[a];
        e1x = face_x[b] - face_x[a]; e1y = face_y[b] - face_y[a];
        e1z = face_z[b] - face_z[a];
        e2x = face_x[p] - face_x[a]; e2y = face_y[p] - face_y[a];
        e2z = face_z[p] - face_z[a];
        d00 = e0x * e0x + e0y * e0y + e0z * e0z;
        d01 = e0x * e1x + e0y * e1y + e0z * e1z;
        d02 = e0x * e2x + e0y * e2y + e0z * e2z;
        d11 = e1x * e1x + e1y * e1y + e1z * e1z;
        d12 = e1x * e2x + e1y * e2y + e1z * e2z;
        den = d00 * d11 - d01 * d01;
        if (den == 0) return 0;
        u = d11 * d02 - d01 * d12;
        v = d00 * d12 - d01 * d02;
        return (u > 0) && (v > 0) && (u + v < den);
    endfunction

    // Clips the stored face and queues the triangles or status it yields.
    function automatic void triangulate_face();
        int order[MAX_VERTS];
        int m, i, j, ip, inx, a, b, c;
        bit found, ear;
        longint cr;
        m = face_count;
        if (face_overflow) begin
            add_tri('0, '0, '0, ST_OVF, 1'b1);
        end else if (m < 3) begin
            add_tri('0, '0, '0, ST_FEW, 1'b1);
        end else begin
            for (i = 0; i < m; i++) order[i] = i;
            while (m > 3) begin
                found = 0;
                for (i = 0; i < m && !found; i++) begin
                    ip = (i + m - 1) % m;
                    inx = (i + 1) % m;
                    a = order[ip]; b = order[i]; c = order[inx];
                    cr = (face_x[b] - face_x[a]) * (face_y[c] - face_y[b])
                       - (face_y[b] - face_y[a]) * (face_x[c] - face_x[b]);
                    if (cr <= 0) continue;
                    ear = 1;
                    for (j = 0; j < m && ear; j++) begin
                        if (j == ip || j == i || j == inx) continue;
                        if (strictly_inside(order[j], a, b, c)) ear = 0;
                    end
                    if (ear) begin
                        add_tri(face_idx[a], face_idx[b], face_idx[c], ST_TRI, 1'b0);
                        for (j = i; j + 1 < m; j++) order[j] = order[j + 1];
                        m--;
                        found = 1;
                    end
                end
                if (!found) break;
            end
            if (m == 3)
                add_tri(face_idx[order[0]], face_idx[order[1]], face_idx[order[2]],
                        ST_TRI, 1'b1);
            else
                add_tri('0, '0, '0, ST_DEGEN, 1'b1);
        end
        face_count = 0;
        face_overflow = 0;
    endfunction

    function automatic void take_corner(logic [CORNER_W-1:0] data, logic last);
        if (face_count < MAX_VERTS) begin
            face_idx[face_count] = data[15:0];
            face_x[face_count] = longint'($signed(data[31:16]));
            face_y[face_count] = longint'($signed(data[47:32]));
            face_z[face_count] = longint'($signed(data[63:48]));
            face_count++;
        end else begin
            face_overflow = 1;
        end
        if (last) triangulate_face();
    endfunction

    function automatic void push_corner(int idx, int x, int y, int z, bit last);
        corner_t k;
        k.idx = idx[15:0]; k.x = x[15:0]; k.y = y[15:0]; k.z = z[15:0]; k.last = last;
        corner_queue.insert(corner_queue.size(), k);
    endfunction

    // Star-shaped counterclockwise face from sorted directions and random radii.
    function automatic void push_star_face(int n);
        bit [15:0] mask;
        int cx, cy, r, k, got;
        mask = '0;
        got = 0;
        while (got < n) begin
            k = $urandom_range(15);
            if (!mask[k]) begin
                mask[k] = 1'b1;
                got++;
            end
        end
        cx = int'($urandom_range(40000)) - 20000;
        cy = int'($urandom_range(40000)) - 20000;
        got = 0;
        for (k = 0; k < 16; k++) begin
            if (mask[k]) begin
                got++;
                r = $urandom_range(12000, 20);
                push_corner($urandom_range(65535), cx + dir_x[k] * r / 1000,
                            cy + dir_y[k] * r / 1000,
                            int'($urandom_range(65535)) - 32768, got == n);
            end
        end
    endfunction

    function automatic void push_noise_face(int n);
        for (int k = 0; k < n; k++)
            push_corner($urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535), k == n - 1);
    endfunction

    task automatic report_mismatch(string what, tri_t want);
        $display({"MISMATCH %s: got a=%h b=%h c=%h st=%0d last=%b, ",
                  "want a=%h b=%h c=%h st=%0d last=%b"},
                 what, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                 m_axis_tuser, m_axis_tlast, want.a, want.b, want.c, want.st, want.last);
        error_count++;
    endtask

    // Input driver: a new beat is loaded only when the previous one was taken.
    always @(posedge i_clk) begin
        corner_t k;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if ($urandom_range(63) == 0) steady_in = !steady_in;
            if (in_gap > 0 && !steady_in) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (corner_queue.size() > 0) begin
                k = corner_queue.pop_front();
                s_axis_tdata  <= {k.z, k.y, k.x, k.idx};
                s_axis_tlast  <= k.last;
                s_axis_tvalid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Every accepted corner beat feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            take_corner(s_axis_tdata, s_axis_tlast);
    end

    // Output side: random stalls, then compare each accepted beat.
    always @(posedge i_clk) begin
        tri_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tris.size() == 0) begin
                    want.a = '0;
                    want.b = '0;
                    want.c = '0;
                    want.st = ST_TRI;
                    want.last = 1'b0;
                    report_mismatch("unexpected beat", want);
                end else begin
                    want = expected_tris.pop_front();
                    if (m_axis_tdata[15:0] !== want.a)  report_mismatch("tri_a", want);
                    if (m_axis_tdata[31:16] !== want.b) report_mismatch("tri_b", want);
                    if (m_axis_tdata[47:32] !== want.c) report_mismatch("tri_c", want);
                    if (m_axis_tuser !== want.st)       report_mismatch("status", want);
                    if (m_axis_tlast !== want.last)     report_mismatch("last", want);
                end
            end
            if ($urandom_range(63) == 0) steady_out = !steady_out;
            if (steady_out) begin
                m_axis_tready <= 1'b1;
            end else if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                out_stall = pick_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int n, r;
        // Triangle at the coordinate extremes, passed through unchanged.
        push_corner(16'h0000, -32768, -32768, -32768, 0);
        push_corner(16'hFFFF, 32767, -32768, 32767, 0);
        push_corner(16'h8000, 0, 32767, 0, 1);
        // Faces with one and with two corners.
        push_corner(16'h1234, 5, 5, 5, 1);
        push_corner(16'h0001, 0, 0, 0, 0);
        push_corner(16'h0002, 9, 9, 9, 1);
        // Collinear corners: no convex corner, so no ear.
        push_corner(10, 0, 0, 0, 0);
        push_corner(11, 10, 0, 0, 0);
        push_corner(12, 20, 0, 0, 0);
        push_corner(13, 30, 0, 0, 1);
        // Counterclockwise square.
        push_corner(20, 0, 0, 1, 0);
        push_corner(21, 100, 0, 2, 0);
        push_corner(22, 100, 100, 3, 0);
        push_corner(23, 0, 100, 4, 1);
        // Concave arrow with a reflex corner.
        push_corner(30, 0, 0, 0, 0);
        push_corner(31, 10, 0, 0, 0);
        push_corner(32, 10, 10, 0, 0);
        push_corner(33, 5, 3, 0, 0);
        push_corner(34, 0, 10, 0, 1);
        // Clockwise square: every corner reflex.
        push_corner(40, 0, 0, 0, 0);
        push_corner(41, 0, 100, 0, 0);
        push_corner(42, 100, 100, 0, 0);
        push_corner(43, 100, 0, 0, 1);

        while (corner_queue.size() < 310) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_star_face($urandom_range(8, 3));
            end else if (r < 73) begin
                push_star_face($urandom_range(16, 9));
            end else if (r < 78) begin
                push_noise_face($urandom_range(20, 17));
            end else begin
                push_noise_face($urandom_range(6, 1));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            #1;
            if (corner_queue.size() == 0 && !s_axis_tvalid && expected_tris.size() == 0)
                break;
        end
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_tris.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ect_pkg.sv
hw/rtl/ect_dp.sv
hw/rtl/ect_ctrl.sv
hw/rtl/ear_clipping_triangulator.sv
tb/sv/ear_clipping_triangulator_tb.sv
